FILE: hw/rtl/slot_pool_free_list_allocator_assert.svh
// Assertion macros for the slot pool allocator, clocked on i_clk, reset by i_rst_n
`ifndef SLOT_POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define SLOT_POOL_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define SPA_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/spa_pkg.sv
// Shared constants and types of the slot pool allocator
package spa_pkg;

    localparam int unsigned POOL_SLOTS = 2048;
    localparam int unsigned SLOT_W     = 11;

    typedef logic [SLOT_W-1:0] t_slot;

    localparam logic REQ_ALLOC   = 1'b0;
    localparam logic REQ_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_BLOCKED     = 2'd1,
        ST_EXHAUSTED   = 2'd2,
        ST_BAD_RELEASE = 2'd3
    } t_status;

    typedef enum logic [5:0] {
        S_INIT     = 6'b000001,
        S_IDLE     = 6'b000010,
        S_A_LINK   = 6'b000100,
        S_A_TAIL   = 6'b001000,
        S_R_UNLINK = 6'b010000,
        S_R_PUSH   = 6'b100000
    } t_state;

endpackage

FILE: hw/rtl/spa_ram.sv
// Simple dual-port RAM: one write port, one read port with registered read data
module spa_ram #(
    parameter int unsigned DEPTH = 2048,
    parameter int unsigned WIDTH = 11,
    localparam int unsigned AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/slot_pool_free_list_allocator.sv
// Top level of the slot pool allocator: request sequencer over the link memories
// Each request answers with one result, shown for exactly one cycle on o_done;
// the receiver cannot stall it. A refused allocate (blocked or pool exhausted)
// and a release of the sentinel answer in the cycle after start and leave busy
// low. A successful allocate passes S_A_LINK and S_A_TAIL, a live-slot release
// S_R_UNLINK and S_R_PUSH; a release of a slot not live ends in S_R_UNLINK. These
// steps come from the registered read of the link memories and the single write
// port of the next-link memory, which each successful request writes twice. After
// reset busy stays high while the link memories are swept to their initial lists;
// configuration writes are taken at any time and o_cfg_ready is always high.
`include "slot_pool_free_list_allocator_assert.svh"

module slot_pool_free_list_allocator
    import spa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [SLOT_W-1:0] i_release_slot,
    output logic              o_done,
    output logic [1:0]        o_status,
    output logic [SLOT_W-1:0] o_granted_slot,
    output logic [SLOT_W-1:0] o_live_count,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_spawn_blocked
);

    t_state  r_state, n_state;
    t_slot   r_init_addr, n_init_addr;
    t_slot   r_free_head, n_free_head;
    t_slot   r_tail, n_tail;
    t_slot   r_count, n_count;
    t_slot   r_slot, n_slot;
    logic    r_blocked, n_blocked;
    logic    r_done, n_done;
    t_status r_status, n_status;
    t_slot   r_granted, n_granted;
    t_slot   r_live_count, n_live_count;

    logic    w_accept;
    t_slot   w_raddr;
    logic    w_next_we, w_prev_we, w_live_we;
    t_slot   w_next_waddr, w_prev_waddr, w_live_waddr;
    t_slot   w_next_wdata, w_prev_wdata;
    logic    w_live_wdata;
    t_slot   w_rd_next, w_rd_prev;
    logic    w_rd_live;

    assign busy        = (r_state != S_IDLE);
    assign w_accept    = start && !busy;
    assign o_cfg_ready = 1'b1;
    assign w_raddr     = (r_state == S_IDLE)
                         ? ((i_req_type == REQ_ALLOC) ? r_free_head : i_release_slot)
                         : r_slot;

    spa_ram #(.DEPTH(POOL_SLOTS), .WIDTH(SLOT_W)) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_next_waddr),
        .i_wdata (w_next_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_next)
    );

    spa_ram #(.DEPTH(POOL_SLOTS), .WIDTH(SLOT_W)) u_prev_ram (
        .i_clk   (i_clk),
        .i_we    (w_prev_we),
        .i_waddr (w_prev_waddr),
        .i_wdata (w_prev_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_prev)
    );

    spa_ram #(.DEPTH(POOL_SLOTS), .WIDTH(1)) u_live_ram (
        .i_clk   (i_clk),
        .i_we    (w_live_we),
        .i_waddr (w_live_waddr),
        .i_wdata (w_live_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_live)
    );

    always_comb begin
        n_state      = r_state;
        n_init_addr  = r_init_addr;
        n_free_head  = r_free_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_slot       = r_slot;
        n_blocked    = r_blocked;
        n_done       = 1'b0;
        n_status     = r_status;
        n_granted    = r_granted;
        n_live_count = r_live_count;

        w_next_we    = 1'b0;
        w_next_waddr = r_slot;
        w_next_wdata = '0;
        w_prev_we    = 1'b0;
        w_prev_waddr = r_slot;
        w_prev_wdata = '0;
        w_live_we    = 1'b0;
        w_live_waddr = r_slot;
        w_live_wdata = 1'b0;

        if (i_cfg_valid && o_cfg_ready) begin
            n_blocked = i_cfg_spawn_blocked;
        end

        case (r_state)
            S_INIT: begin
                w_next_we    = 1'b1;
                w_next_waddr = r_init_addr;
                w_next_wdata = (r_init_addr == SLOT_W'(POOL_SLOTS - 1))
                               ? '0 : r_init_addr + 1'b1;
                w_prev_we    = 1'b1;
                w_prev_waddr = r_init_addr;
                w_prev_wdata = (r_init_addr == '0) ? '0 : r_init_addr - 1'b1;
                w_live_we    = 1'b1;
                w_live_waddr = r_init_addr;
                w_live_wdata = 1'b0;
                n_init_addr  = r_init_addr + 1'b1;
                if (r_init_addr == SLOT_W'(POOL_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    if (i_req_type == REQ_ALLOC) begin
                        if (r_blocked) begin
                            n_done       = 1'b1;
                            n_status     = ST_BLOCKED;
                            n_granted    = '0;
                            n_live_count = r_count;
                        end else if (r_count >= SLOT_W'(POOL_SLOTS - 1)
                                     || r_free_head == '0) begin
                            n_done       = 1'b1;
                            n_status     = ST_EXHAUSTED;
                            n_granted    = '0;
                            n_live_count = r_count;
                        end else begin
                            n_slot  = r_free_head;
                            n_state = S_A_LINK;
                        end
                    end else begin
                        if (i_release_slot == '0
                            || 32'(i_release_slot) >= POOL_SLOTS) begin
                            n_done       = 1'b1;
                            n_status     = ST_BAD_RELEASE;
                            n_granted    = '0;
                            n_live_count = r_count;
                        end else begin
                            n_slot  = i_release_slot;
                            n_state = S_R_UNLINK;
                        end
                    end
                end
            end
            S_A_LINK: begin
                w_next_we    = 1'b1;
                w_next_waddr = r_slot;
                w_next_wdata = '0;
                w_prev_we    = 1'b1;
                w_prev_waddr = r_slot;
                w_prev_wdata = r_tail;
                w_live_we    = 1'b1;
                w_live_waddr = r_slot;
                w_live_wdata = 1'b1;
                n_free_head  = w_rd_next;
                n_state      = S_A_TAIL;
            end
            S_A_TAIL: begin
                w_next_we    = 1'b1;
                w_next_waddr = r_tail;
                w_next_wdata = r_slot;
                n_tail       = r_slot;
                n_count      = r_count + 1'b1;
                n_done       = 1'b1;
                n_status     = ST_OK;
                n_granted    = r_slot;
                n_live_count = r_count + 1'b1;
                n_state      = S_IDLE;
            end
            S_R_UNLINK: begin
                if (!w_rd_live) begin
                    n_done       = 1'b1;
                    n_status     = ST_BAD_RELEASE;
                    n_granted    = '0;
                    n_live_count = r_count;
                    n_state      = S_IDLE;
                end else begin
                    w_next_we    = 1'b1;
                    w_next_waddr = w_rd_prev;
                    w_next_wdata = (r_tail == r_slot) ? '0 : w_rd_next;
                    w_prev_we    = (w_rd_next != '0);
                    w_prev_waddr = w_rd_next;
                    w_prev_wdata = w_rd_prev;
                    w_live_we    = 1'b1;
                    w_live_waddr = r_slot;
                    w_live_wdata = 1'b0;
                    if (r_tail == r_slot) begin
                        n_tail = w_rd_prev;
                    end
                    if (r_count != '0) begin
                        n_count = r_count - 1'b1;
                    end
                    n_state = S_R_PUSH;
                end
            end
            S_R_PUSH: begin
                w_next_we    = 1'b1;
                w_next_waddr = r_slot;
                w_next_wdata = r_free_head;
                n_free_head  = r_slot;
                n_done       = 1'b1;
                n_status     = ST_OK;
                n_granted    = '0;
                n_live_count = r_count;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_init_addr <= '0;
            r_free_head <= SLOT_W'(1);
            r_tail      <= '0;
            r_count     <= '0;
            r_blocked   <= 1'b0;
            r_done      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_init_addr <= n_init_addr;
            r_free_head <= n_free_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_blocked   <= n_blocked;
            r_done      <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_status     <= n_status;
        r_granted    <= n_granted;
        r_live_count <= n_live_count;
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_granted_slot = r_granted;
    assign o_live_count   = r_live_count;

    `SPA_ASSERT_NEXT(a_accept_answered, start && !busy, o_done || busy, "accepted request lost")
    `SPA_ASSERT_HOLDS(a_count_bound, o_done, o_live_count <= SLOT_W'(POOL_SLOTS - 1), "live count overflow")
    `SPA_ASSERT_HOLDS(a_grant_ok, o_done && (o_granted_slot != '0), o_status == ST_OK, "slot granted on failure")

endmodule

FILE: sim/tb.sv
// Testbench of the slot pool allocator: link-list scoreboard, directed and random requests
module tb;
    import spa_pkg::*;

    typedef struct {
        t_status status;
        t_slot   slot;
        t_slot   live_count;
    } t_alloc_result;

    class alloc_tracker;
        t_slot         next_lk[POOL_SLOTS];
        t_slot         prev_lk[POOL_SLOTS];
        bit            live[POOL_SLOTS];
        t_slot         free_head;
        t_slot         used_tail;
        t_slot         live_total;
        t_slot         peak_live;
        bit            blocked;
        t_slot         live_slots[$];
        t_alloc_result expected_results[$];
        int            errors;
        int            requests;
        int            checked;

        function new();
            for (int i = 0; i < POOL_SLOTS; i++) begin
                next_lk[i] = (i == POOL_SLOTS - 1) ? '0 : t_slot'(i + 1);
                prev_lk[i] = (i == 0) ? '0 : t_slot'(i - 1);
                live[i]    = 1'b0;
            end
            free_head  = t_slot'(1);
            used_tail  = '0;
            live_total = '0;
            peak_live  = '0;
            blocked    = 1'b0;
            errors     = 0;
            requests   = 0;
            checked    = 0;
        endfunction

        task report_mismatch(string msg);
            $display("mismatch at result %0d: %s", checked, msg);
            errors++;
        endtask

        function t_slot pick_live();
            return live_slots[$urandom_range(live_slots.size() - 1)];
        endfunction

        function void note_request(logic req, t_slot slot);
            t_alloc_result r;
            t_slot         ns;
            t_slot         nx;
            t_slot         pv;
            int            hit[$];
            requests++;
            r.slot = '0;
            if (req == REQ_ALLOC) begin
                if (blocked) begin
                    r.status = ST_BLOCKED;
                end else if (live_total >= POOL_SLOTS - 1 || free_head == '0) begin
                    r.status = ST_EXHAUSTED;
                end else begin
                    ns                 = free_head;
                    free_head          = next_lk[ns];
                    prev_lk[free_head] = '0;
                    next_lk[ns]        = '0;
                    next_lk[used_tail] = ns;
                    prev_lk[ns]        = used_tail;
                    used_tail          = ns;
                    live[ns]           = 1'b1;
                    live_total++;
                    live_slots.push_back(ns);
                    r.status = ST_OK;
                    r.slot   = ns;
                end
            end else if (slot == '0 || !live[slot]) begin
                r.status = ST_BAD_RELEASE;
            end else begin
                nx = next_lk[slot];
                pv = prev_lk[slot];
                if (live_total > 0) live_total--;
                if (nx != '0) prev_lk[nx] = pv;
                next_lk[pv] = nx;
                if (used_tail == slot) begin
                    used_tail   = pv;
                    next_lk[pv] = '0;
                end
                prev_lk[slot]      = '0;
                prev_lk[free_head] = slot;
                next_lk[slot]      = free_head;
                free_head          = slot;
                live[slot]         = 1'b0;
                hit = live_slots.find_first_index(x) with (x == slot);
                if (hit.size() > 0) live_slots.delete(hit[0]);
                r.status = ST_OK;
            end
            if (live_total > peak_live) peak_live = live_total;
            r.live_count = live_total;
            expected_results.push_back(r);
        endfunction

        task check_result(logic [1:0] st, t_slot slot, t_slot cnt);
            t_alloc_result e;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("result with nothing outstanding, status %0d", st));
                return;
            end
            e = expected_results.pop_front();
            checked++;
            if (st !== e.status)
                report_mismatch($sformatf("status %0d, expected %0d", st, e.status));
            if (slot !== e.slot)
                report_mismatch($sformatf("granted slot %0d, expected %0d", slot, e.slot));
            if (cnt !== e.live_count)
                report_mismatch($sformatf("live count %0d, expected %0d", cnt, e.live_count));
        endtask
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         start;
    logic         busy;
    logic         i_req_type;
    t_slot        i_release_slot;
    logic         o_done;
    logic [1:0]   o_status;
    t_slot        o_granted_slot;
    t_slot        o_live_count;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic         i_cfg_spawn_blocked;
    alloc_tracker tracker;
    int           gap_pct;

    slot_pool_free_list_allocator DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .start               (start),
        .busy                (busy),
        .i_req_type          (i_req_type),
        .i_release_slot      (i_release_slot),
        .o_done              (o_done),
        .o_status            (o_status),
        .o_granted_slot      (o_granted_slot),
        .o_live_count        (o_live_count),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_spawn_blocked (i_cfg_spawn_blocked)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_done === 1'b1)
            tracker.check_result(o_status, o_granted_slot, o_live_count);
    end

    task automatic drive_request(input logic req, input t_slot slot);
        start          <= 1'b1;
        i_req_type     <= req;
        i_release_slot <= slot;
        do @(posedge i_clk); while (busy !== 1'b0);
        tracker.note_request(req, slot);
        if ($urandom_range(99) < gap_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    task automatic settle();
        start <= 1'b0;
        while (tracker.expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_cfg(input bit blk);
        settle();
        i_cfg_valid         <= 1'b1;
        i_cfg_spawn_blocked <= blk;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        tracker.blocked = blk;
        i_cfg_valid     <= 1'b0;
    endtask

    task automatic run_random(input int n_items);
        int roll;
        for (int k = 0; k < n_items; k++) begin
            roll = $urandom_range(99);
            if (roll < 45)
                drive_request(REQ_ALLOC, t_slot'($urandom));
            else if (roll < 85 && tracker.live_slots.size() > 0)
                drive_request(REQ_RELEASE, tracker.pick_live());
            else if (roll < 92)
                drive_request(REQ_RELEASE, t_slot'($urandom));
            else if (roll < 96)
                drive_request(REQ_RELEASE, tracker.free_head);
            else
                drive_request(REQ_RELEASE, ($urandom_range(1)) ? '0 : '1);
        end
    endtask

    initial begin
        i_rst_n             = 1'b0;
        start               = 1'b0;
        i_req_type          = REQ_ALLOC;
        i_release_slot      = '0;
        i_cfg_valid         = 1'b0;
        i_cfg_spawn_blocked = 1'b0;
        gap_pct             = 0;
        tracker             = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_cfg(1'b0);
        drive_request(REQ_RELEASE, '0);
        drive_request(REQ_RELEASE, '1);
        drive_request(REQ_RELEASE, t_slot'(5));
        repeat (4) drive_request(REQ_ALLOC, '1);
        drive_request(REQ_RELEASE, t_slot'(2));
        drive_request(REQ_RELEASE, t_slot'(4));
        drive_request(REQ_RELEASE, t_slot'(1));
        drive_request(REQ_RELEASE, t_slot'(2));
        drive_request(REQ_ALLOC, '0);
        drive_request(REQ_ALLOC, '1);
        write_cfg(1'b1);
        drive_request(REQ_ALLOC, '0);
        drive_request(REQ_RELEASE, tracker.pick_live());
        drive_request(REQ_ALLOC, '1);
        write_cfg(1'b0);

        run_random(120);
        write_cfg(1'b1);
        gap_pct = 57;
        run_random(40);
        write_cfg(1'b0);
        run_random(100);
        gap_pct = 13;
        run_random(80);
        gap_pct = 0;
        run_random(40);

        settle();
        $display("covered %0d requests, %0d results checked, peak live count %0d",
                 tracker.requests, tracker.checked, tracker.peak_live);
        $display("phases: no gaps, heavy and light sender gaps, spawn blocked, bad releases");
        if (tracker.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout with %0d results outstanding", tracker.expected_results.size());
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/spa_pkg.sv
hw/rtl/spa_ram.sv
hw/rtl/slot_pool_free_list_allocator.sv
sim/tb.sv
